>>> sv/rbd_pkg.sv
// Shared types and constants for the RGB box downsampler.
// Holds register widths, reset values, the divider operand select and the
// command and status structures that join the controller and the datapath.
package rbd_pkg;

    localparam int CFG_W          = 12;
    localparam int FACTOR_CFG_W   = 5;
    localparam int CFG_IDX_W      = 2;
    localparam int PIX_W          = 8;
    localparam int ROW_W          = 11;
    localparam int HEIGHT_LIMIT   = 2048;
    localparam int DEF_MAX_WIDTH  = 2048;
    localparam int DEF_MAX_FACTOR = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FACTOR  = 2'd2;

    localparam logic [CFG_W-1:0]        RST_SOURCE_WIDTH  = 12'd640;
    localparam logic [CFG_W-1:0]        RST_SOURCE_HEIGHT = 12'd480;
    localparam logic [FACTOR_CFG_W-1:0] RST_BLOCK_FACTOR  = 5'd2;

    typedef enum logic [2:0] {
        DS_PIXEL,
        DS_WIDTH,
        DS_HEIGHT,
        DS_COLUMN,
        DS_ROW
    } t_div_sel;

    typedef struct packed {
        logic     accept;
        logic     mem_read;
        logic     mem_write;
        logic     div_start;
        t_div_sel div_sel;
        logic     cfg_store;
        logic     out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic active;
        logic emit;
        logic div_busy;
        logic out_full;
    } t_dp_status;

endpackage

>>> sv/rbd_div.sv
// Restoring divider lane: one quotient bit per cycle.
// Standalone; used by the downsampler datapath for averages and geometry.
module rbd_div #(
    parameter int DW = 16,
    parameter int AW = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [AW-1:0] i_divisor,
    output logic          o_busy,
    output logic [DW-1:0] o_quot,
    output logic [AW-1:0] o_rem
);

    localparam int CNTW = $clog2(DW + 1);

    logic [CNTW-1:0] r_cnt;
    logic [DW-1:0]   r_quot;
    logic [AW-1:0]   r_rem;
    logic [AW-1:0]   r_dvs;

    logic [AW:0]   trial;
    logic          fits;
    logic [AW-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quot[DW-1]};
        fits  = trial >= {1'b0, r_dvs};
        n_rem = fits ? AW'(trial - {1'b0, r_dvs}) : trial[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNTW'(DW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_quot <= {r_quot[DW-2:0], fits};
            r_rem  <= n_rem;
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

endmodule

>>> sv/rbd_ctrl.sv
// Controller state machine of the RGB box downsampler.
// Depends on rbd_pkg for the command and status structures.
module rbd_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_cfg_we,
    input  logic               i_out_stall,
    input  rbd_pkg::t_dp_status i_status,
    output logic               o_in_stall,
    output rbd_pkg::t_dp_cmd   o_cmd
);

    import rbd_pkg::*;

    typedef enum logic [2:0] {
        S_CFG_START,
        S_CFG_WAIT,
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_DIV_WAIT,
        S_PUSH
    } t_state;

    t_state   r_state,   n_state;
    logic     r_dirty,   n_dirty;
    t_div_sel r_cfg_sel, n_cfg_sel;
    logic     accept;

    assign o_in_stall = !(r_state == S_IDLE && !r_dirty && !i_cfg_we);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state       = r_state;
        n_dirty       = r_dirty | i_cfg_we;
        n_cfg_sel     = r_cfg_sel;
        o_cmd         = '0;
        o_cmd.div_sel = r_cfg_sel;
        unique case (r_state)
            S_CFG_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_CFG_WAIT;
            end
            S_CFG_WAIT: begin
                if (!i_status.div_busy) begin
                    o_cmd.cfg_store = 1'b1;
                    unique case (r_cfg_sel)
                        DS_WIDTH: begin
                            n_cfg_sel = DS_HEIGHT;
                            n_state   = S_CFG_START;
                        end
                        DS_HEIGHT: begin
                            n_cfg_sel = DS_COLUMN;
                            n_state   = S_CFG_START;
                        end
                        DS_COLUMN: begin
                            n_cfg_sel = DS_ROW;
                            n_state   = S_CFG_START;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_IDLE: begin
                if (r_dirty) begin
                    n_dirty   = i_cfg_we;
                    n_cfg_sel = DS_WIDTH;
                    n_state   = S_CFG_START;
                end else if (accept) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.active) begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_cmd.mem_read = 1'b1;
                n_state        = S_UPDATE;
            end
            S_UPDATE: begin
                o_cmd.mem_write = 1'b1;
                if (i_status.emit) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_sel   = DS_PIXEL;
                    n_state         = S_DIV_WAIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DIV_WAIT: begin
                if (!i_status.div_busy) begin
                    n_state = S_PUSH;
                end
            end
            S_PUSH: begin
                if (!i_status.out_full || !i_out_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CFG_START;
            r_dirty   <= 1'b0;
            r_cfg_sel <= DS_WIDTH;
        end else begin
            r_state   <= n_state;
            r_dirty   <= n_dirty;
            r_cfg_sel <= n_cfg_sel;
        end
    end

endmodule

>>> sv/rbd_datapath.sv
// Datapath of the RGB box downsampler: configuration, position counters,
// column accumulator memory, divider lanes and output register.
// Depends on rbd_pkg and rbd_div.
module rbd_datapath #(
    parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic [rbd_pkg::PIX_W-1:0]      i_chan_a,
    input  logic [rbd_pkg::PIX_W-1:0]      i_chan_b,
    input  logic [rbd_pkg::PIX_W-1:0]      i_chan_c,
    input  logic                           i_frame_start,
    input  rbd_pkg::t_dp_cmd               i_cmd,
    output rbd_pkg::t_dp_status            o_status,
    input  logic                           i_out_stall,
    output logic                           o_out_valid,
    output logic [rbd_pkg::PIX_W-1:0]      o_avg_a,
    output logic [rbd_pkg::PIX_W-1:0]      o_avg_b,
    output logic [rbd_pkg::PIX_W-1:0]      o_avg_c,
    output logic                           o_line_end,
    output logic                           o_frame_end
);

    import rbd_pkg::*;

    localparam int FW  = $clog2(MAX_FACTOR);
    localparam int FEW = FW + 1;
    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int CW  = PIX_W + 2 * FW;
    localparam int AW  = 2 * FW + 1;
    localparam int DW  = (CW > CFG_W) ? CW : CFG_W;

    logic [CFG_W-1:0]        r_src_width;
    logic [CFG_W-1:0]        r_src_height;
    logic [FACTOR_CFG_W-1:0] r_factor;

    logic [FEW-1:0]   f_eff;
    logic [FEW-1:0]   f_m1;
    logic [2*FEW-1:0] area;
    logic [CFG_W-1:0] w_eff;
    logic [CFG_W-1:0] h_eff;

    logic [XW-1:0]    r_col,  r_oc;
    logic [ROW_W-1:0] r_row,  r_orow;
    logic [FW-1:0]    r_ibc,  r_ibr, r_cm, r_rm;
    logic [CFG_W-1:0] r_ow,   r_owf, r_oh, r_ohf;

    logic [XW-1:0]    col_e,  oc_e,   n_col, n_oc;
    logic [ROW_W-1:0] row_e,  orow_e, n_row, n_orow;
    logic [FW-1:0]    ibc_e,  ibr_e,  cm_e,  rm_e;
    logic [FW-1:0]    n_ibc,  n_ibr,  n_cm,  n_rm;
    logic             active, first,  emit,  le, fe;
    logic             col_last, row_last;

    logic [PIX_W-1:0] r_pix_a, r_pix_b, r_pix_c;
    logic             r_first, r_emit, r_le, r_fe;
    logic [XW-1:0]    r_addr;

    logic [3*CW-1:0]  r_mem [MAX_WIDTH];
    logic [3*CW-1:0]  r_rd_data;
    logic [CW-1:0]    sum_a, sum_b, sum_c;

    logic [DW-1:0]    dividend0;
    logic [AW-1:0]    divisor;
    logic [DW-1:0]    quot0, quot1, quot2;
    logic [AW-1:0]    rem0;
    logic             busy0, busy1, busy2;

    logic             r_out_valid;
    logic [PIX_W-1:0] r_avg_a, r_avg_b, r_avg_c;
    logic             r_line_end, r_frame_end;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= RST_SOURCE_WIDTH;
            r_src_height <= RST_SOURCE_HEIGHT;
            r_factor     <= RST_BLOCK_FACTOR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:  r_src_width  <= i_cfg_data;
                CFG_SOURCE_HEIGHT: r_src_height <= i_cfg_data;
                CFG_BLOCK_FACTOR:  r_factor     <= i_cfg_data[FACTOR_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_factor == '0) begin
            f_eff = FEW'(1);
        end else if (32'(r_factor) > 32'(MAX_FACTOR)) begin
            f_eff = FEW'(MAX_FACTOR);
        end else begin
            f_eff = FEW'(r_factor);
        end
        if (r_src_width == '0) begin
            w_eff = CFG_W'(1);
        end else if (32'(r_src_width) > 32'(MAX_WIDTH)) begin
            w_eff = CFG_W'(MAX_WIDTH);
        end else begin
            w_eff = r_src_width;
        end
        if (r_src_height == '0) begin
            h_eff = CFG_W'(1);
        end else if (32'(r_src_height) > 32'(HEIGHT_LIMIT)) begin
            h_eff = CFG_W'(HEIGHT_LIMIT);
        end else begin
            h_eff = r_src_height;
        end
        f_m1 = f_eff - FEW'(1);
        area = f_eff * f_eff;
    end

    // Position of the incoming pixel and the counters after it.
    always_comb begin
        col_e  = i_frame_start ? '0 : r_col;
        row_e  = i_frame_start ? '0 : r_row;
        ibc_e  = i_frame_start ? '0 : r_ibc;
        ibr_e  = i_frame_start ? '0 : r_ibr;
        oc_e   = i_frame_start ? '0 : r_oc;
        cm_e   = i_frame_start ? '0 : r_cm;
        orow_e = i_frame_start ? '0 : r_orow;
        rm_e   = i_frame_start ? '0 : r_rm;

        active = (32'(col_e) < 32'(r_owf)) && (32'(row_e) < 32'(r_ohf));
        first  = (ibr_e == '0) && (ibc_e == '0);
        emit   = (32'(ibr_e) == 32'(f_m1)) && (32'(ibc_e) == 32'(f_m1));
        le     = 32'(oc_e) == 32'(r_ow) - 32'd1;
        fe     = le && (32'(orow_e) == 32'(r_oh) - 32'd1);

        col_last = 32'(col_e) >= 32'(w_eff) - 32'd1;
        row_last = 32'(row_e) >= 32'(h_eff) - 32'd1;

        n_col  = col_e;
        n_row  = row_e;
        n_ibc  = ibc_e;
        n_ibr  = ibr_e;
        n_oc   = oc_e;
        n_cm   = cm_e;
        n_orow = orow_e;
        n_rm   = rm_e;
        if (col_last) begin
            n_col = '0;
            n_ibc = '0;
            n_oc  = '0;
            n_cm  = '0;
            if (row_last) begin
                n_row  = '0;
                n_ibr  = '0;
                n_orow = '0;
                n_rm   = '0;
            end else begin
                n_row = row_e + ROW_W'(1);
                n_ibr = (32'(ibr_e) >= 32'(f_m1)) ? '0 : ibr_e + FW'(1);
                if (32'(rm_e) >= 32'(f_m1)) begin
                    n_rm   = '0;
                    n_orow = orow_e + ROW_W'(1);
                end else begin
                    n_rm = rm_e + FW'(1);
                end
            end
        end else begin
            n_col = col_e + XW'(1);
            n_ibc = (32'(ibc_e) >= 32'(f_m1)) ? '0 : ibc_e + FW'(1);
            if (32'(cm_e) >= 32'(f_m1)) begin
                n_cm = '0;
                n_oc = oc_e + XW'(1);
            end else begin
                n_cm = cm_e + FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_ibc  <= '0;
            r_ibr  <= '0;
            r_oc   <= '0;
            r_cm   <= '0;
            r_orow <= '0;
            r_rm   <= '0;
            r_ow   <= '0;
            r_owf  <= '0;
            r_oh   <= '0;
            r_ohf  <= '0;
            r_emit <= 1'b0;
        end else if (i_cmd.accept) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_ibc  <= n_ibc;
            r_ibr  <= n_ibr;
            r_oc   <= n_oc;
            r_cm   <= n_cm;
            r_orow <= n_orow;
            r_rm   <= n_rm;
            r_emit <= emit;
        end else if (i_cmd.cfg_store) begin
            unique case (i_cmd.div_sel)
                DS_WIDTH: begin
                    r_ow  <= CFG_W'(quot0);
                    r_owf <= w_eff - CFG_W'(rem0);
                end
                DS_HEIGHT: begin
                    r_oh  <= CFG_W'(quot0);
                    r_ohf <= h_eff - CFG_W'(rem0);
                end
                DS_COLUMN: begin
                    r_oc <= XW'(quot0);
                    r_cm <= FW'(rem0);
                end
                DS_ROW: begin
                    r_orow <= ROW_W'(quot0);
                    r_rm   <= FW'(rem0);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_pix_a <= i_chan_a;
            r_pix_b <= i_chan_b;
            r_pix_c <= i_chan_c;
            r_first <= first;
            r_le    <= le;
            r_fe    <= fe;
            r_addr  <= oc_e;
        end
    end

    // Column accumulators: three channel sums per output column.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_read) begin
            r_rd_data <= r_mem[r_addr];
        end
        if (i_cmd.mem_write) begin
            r_mem[r_addr] <= {sum_c, sum_b, sum_a};
        end
    end

    always_comb begin
        sum_a = r_first ? CW'(r_pix_a) : r_rd_data[CW-1:0] + CW'(r_pix_a);
        sum_b = r_first ? CW'(r_pix_b) : r_rd_data[2*CW-1:CW] + CW'(r_pix_b);
        sum_c = r_first ? CW'(r_pix_c) : r_rd_data[3*CW-1:2*CW] + CW'(r_pix_c);
    end

    always_comb begin
        unique case (i_cmd.div_sel)
            DS_PIXEL:  dividend0 = DW'(sum_a);
            DS_WIDTH:  dividend0 = DW'(w_eff);
            DS_HEIGHT: dividend0 = DW'(h_eff);
            DS_COLUMN: dividend0 = DW'(r_col);
            DS_ROW:    dividend0 = DW'(r_row);
            default:   dividend0 = '0;
        endcase
        divisor = (i_cmd.div_sel == DS_PIXEL) ? AW'(area) : AW'(f_eff);
    end

    rbd_div #(.DW(DW), .AW(AW)) u_div_a (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (dividend0),
        .i_divisor  (divisor),
        .o_busy     (busy0),
        .o_quot     (quot0),
        .o_rem      (rem0)
    );

    rbd_div #(.DW(DW), .AW(AW)) u_div_b (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DW'(sum_b)),
        .i_divisor  (divisor),
        .o_busy     (busy1),
        .o_quot     (quot1),
        .o_rem      ()
    );

    rbd_div #(.DW(DW), .AW(AW)) u_div_c (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (DW'(sum_c)),
        .i_divisor  (divisor),
        .o_busy     (busy2),
        .o_quot     (quot2),
        .o_rem      ()
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg_a     <= quot0[PIX_W-1:0];
            r_avg_b     <= quot1[PIX_W-1:0];
            r_avg_c     <= quot2[PIX_W-1:0];
            r_line_end  <= r_le;
            r_frame_end <= r_fe;
        end
    end

    always_comb begin
        o_status.active   = active;
        o_status.emit     = r_emit;
        o_status.div_busy = busy0 | busy1 | busy2;
        o_status.out_full = r_out_valid;
    end

    assign o_out_valid = r_out_valid;
    assign o_avg_a     = r_avg_a;
    assign o_avg_b     = r_avg_b;
    assign o_avg_c     = r_avg_c;
    assign o_line_end  = r_line_end;
    assign o_frame_end = r_frame_end;

endmodule

>>> sv/rgb_box_downsampler_unit.sv
// Top level of the RGB box downsampler: controller plus datapath.
// Depends on rbd_pkg, rbd_ctrl and rbd_datapath.
// A pixel outside the output blocks is taken in the idle state only; any other also goes
// through the read and update states. A block's last pixel then waits for the divider
// lanes (DW is 16 by default) and loads the output register. Reset and each configuration
// write stall the input during the geometry update; accumulators are not cleared.
module rgb_box_downsampler_unit #(
    parameter int MAX_WIDTH  = rbd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_FACTOR = rbd_pkg::DEF_MAX_FACTOR
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rbd_pkg::PIX_W-1:0]     i_chan_a,
    input  logic [rbd_pkg::PIX_W-1:0]     i_chan_b,
    input  logic [rbd_pkg::PIX_W-1:0]     i_chan_c,
    input  logic                          i_frame_start,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [rbd_pkg::PIX_W-1:0]     o_avg_a,
    output logic [rbd_pkg::PIX_W-1:0]     o_avg_b,
    output logic [rbd_pkg::PIX_W-1:0]     o_avg_c,
    output logic                          o_line_end,
    output logic                          o_frame_end
);

    import rbd_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    rbd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_we    (i_cfg_we),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    rbd_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_FACTOR (MAX_FACTOR)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_chan_a      (i_chan_a),
        .i_chan_b      (i_chan_b),
        .i_chan_c      (i_chan_c),
        .i_frame_start (i_frame_start),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_avg_a       (o_avg_a),
        .o_avg_b       (o_avg_b),
        .o_avg_c       (o_avg_c),
        .o_line_end    (o_line_end),
        .o_frame_end   (o_frame_end)
    );

endmodule

>>> sv/rbd_checker.sv
// Port-level checks for the RGB box downsampler, attached by bind.
// Depends on the ports of rgb_box_downsampler_unit only.
module rbd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_we,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_avg_a,
    input logic [7:0] o_avg_b,
    input logic [7:0] o_avg_c,
    input logic       o_line_end,
    input logic       o_frame_end
);

    // A stalled result transaction stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result withdrawn while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_avg_a) && $stable(o_avg_b)
            && $stable(o_avg_c) && $stable(o_line_end) && $stable(o_frame_end))
        else $error("stalled result changed");

    // The last block of a frame is always the last of its output line.
    a_frame_end_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_frame_end || o_line_end))
        else $error("frame end without line end");

    // A configuration write forces a geometry update before the next pixel.
    a_cfg_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> o_in_stall)
        else $error("pixel input open straight after a configuration write");

endmodule

bind rgb_box_downsampler_unit rbd_checker u_rbd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_avg_a     (o_avg_a),
    .o_avg_b     (o_avg_b),
    .o_avg_c     (o_avg_c),
    .o_line_end  (o_line_end),
    .o_frame_end (o_frame_end)
);

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for rgb_box_downsampler_unit: directed and random frames
// go through a box-average predictor, and each output transaction is compared with it.
// Depends on rbd_pkg and the rgb_box_downsampler_unit RTL.
module tb_top;
    import rbd_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_SHOWN      = 10;
    localparam int LONG_HOLD      = 400;
    localparam int RANDOM_ITEMS   = 100;
    localparam int COL_W          = $clog2(DEF_MAX_WIDTH);
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] a;
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] c;
        logic             line_end;
        logic             frame_end;
    } t_avg_pix;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]     i_cfg_data    = '0;
    logic                 i_in_valid    = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_chan_a      = '0;
    logic [PIX_W-1:0]     i_chan_b      = '0;
    logic [PIX_W-1:0]     i_chan_c      = '0;
    logic                 i_frame_start = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall   = 1'b0;
    logic [PIX_W-1:0]     o_avg_a;
    logic [PIX_W-1:0]     o_avg_b;
    logic [PIX_W-1:0]     o_avg_c;
    logic                 o_line_end;
    logic                 o_frame_end;

    // Shadow of the configuration registers and of the downsampler state.
    logic [CFG_W-1:0]        width_reg  = RST_SOURCE_WIDTH;
    logic [CFG_W-1:0]        height_reg = RST_SOURCE_HEIGHT;
    logic [FACTOR_CFG_W-1:0] factor_reg = RST_BLOCK_FACTOR;
    bit [17:0]               sum_a [DEF_MAX_WIDTH];
    bit [17:0]               sum_b [DEF_MAX_WIDTH];
    bit [17:0]               sum_c [DEF_MAX_WIDTH];
    int unsigned             src_col = 0;
    int unsigned             src_row = 0;
    int unsigned             blk_col = 0;
    int unsigned             blk_row = 0;

    t_avg_pix    pending_avgs [$];
    int unsigned mismatches   = 0;
    int unsigned sent_items   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned stall_left   = 0;
    int unsigned long_hold_req = 0;
    bit          idle_on      = 1'b1;

    rgb_box_downsampler_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_chan_a      (i_chan_a),
        .i_chan_b      (i_chan_b),
        .i_chan_c      (i_chan_c),
        .i_frame_start (i_frame_start),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_avg_a       (o_avg_a),
        .o_avg_b       (o_avg_b),
        .o_avg_c       (o_avg_c),
        .o_line_end    (o_line_end),
        .o_frame_end   (o_frame_end)
    );

    always #2 i_clk = ~i_clk;

    function automatic int unsigned clamp_size(input int unsigned v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    function automatic int unsigned frame_pixels();
        return clamp_size(32'(width_reg), DEF_MAX_WIDTH)
               * clamp_size(32'(height_reg), HEIGHT_LIMIT);
    endfunction

    task automatic downsample_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                                    input logic [PIX_W-1:0] c, input logic fs);
        int unsigned      f;
        int unsigned      w;
        int unsigned      h;
        int unsigned      ow;
        int unsigned      oh;
        logic [COL_W-1:0] oc;
        int unsigned      area;
        t_avg_pix         avg;
        f  = clamp_size(32'(factor_reg), DEF_MAX_FACTOR);
        w  = clamp_size(32'(width_reg), DEF_MAX_WIDTH);
        h  = clamp_size(32'(height_reg), HEIGHT_LIMIT);
        ow = w / f;
        oh = h / f;
        if (fs) begin
            src_col = 0;
            src_row = 0;
            blk_col = 0;
            blk_row = 0;
        end
        if (src_col < ow * f && src_row < oh * f) begin
            oc = COL_W'(src_col / f);
            if (blk_row == 0 && blk_col == 0) begin
                sum_a[oc] = 18'(a);
                sum_b[oc] = 18'(b);
                sum_c[oc] = 18'(c);
            end else begin
                sum_a[oc] = sum_a[oc] + 18'(a);
                sum_b[oc] = sum_b[oc] + 18'(b);
                sum_c[oc] = sum_c[oc] + 18'(c);
            end
            if (blk_row == f - 1 && blk_col == f - 1) begin
                area          = f * f;
                avg.a         = PIX_W'(32'(sum_a[oc]) / area);
                avg.b         = PIX_W'(32'(sum_b[oc]) / area);
                avg.c         = PIX_W'(32'(sum_c[oc]) / area);
                avg.line_end  = (32'(oc) == ow - 1);
                avg.frame_end = avg.line_end && (src_row / f == oh - 1);
                pending_avgs.push_back(avg);
            end
        end
        if (src_col >= w - 1) begin
            src_col = 0;
            blk_col = 0;
            if (src_row >= h - 1) begin
                src_row = 0;
                blk_row = 0;
            end else begin
                src_row++;
                blk_row = (blk_row >= f - 1) ? 0 : blk_row + 1;
            end
        end else begin
            src_col++;
            blk_col = (blk_col >= f - 1) ? 0 : blk_col + 1;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] b,
                              input logic [PIX_W-1:0] c, input logic fs);
        i_chan_a      <= a;
        i_chan_b      <= b;
        i_chan_c      <= c;
        i_frame_start <= fs;
        i_in_valid    <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) break;
        end
        downsample_pixel(a, b, c, fs);
        sent_items++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic send_frame(input int unsigned n, input bit fs_first);
        for (int unsigned i = 0; i < n; i++) begin
            send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                       PIX_W'($urandom_range(0, 255)), fs_first && i == 0);
        end
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_avgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            CFG_SOURCE_WIDTH:  width_reg  = data;
            CFG_SOURCE_HEIGHT: height_reg = data;
            CFG_BLOCK_FACTOR:  factor_reg = data[FACTOR_CFG_W-1:0];
            default: ;
        endcase
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic [CFG_W-1:0] f);
        wait_idle();
        write_reg(CFG_SOURCE_WIDTH, w);
        write_reg(CFG_SOURCE_HEIGHT, h);
        write_reg(CFG_BLOCK_FACTOR, f);
    endtask

    task automatic test_reset_defaults();
        // The first source row at the reset geometry gives no result; a factor of 1 then
        // gives one result for every pixel of the same row.
        send_frame(8, 1'b0);
        wait_idle();
        write_reg(CFG_BLOCK_FACTOR, 12'd1);
        send_frame(24, 1'b0);
    endtask

    task automatic test_directed_blocks();
        configure(12'd4, 12'd2, 12'd2);
        for (int unsigned i = 0; i < 8; i++) begin
            if (i % 4 < 2) send_pixel(8'hFF, 8'h00, 8'hAA, i == 0);
            else send_pixel(8'h00, 8'hFF, 8'h55, 1'b0);
        end
        send_frame(3, 1'b1);
        send_frame(8, 1'b1);
        configure(12'd2, 12'd2, 12'd1);
        send_frame(4, 1'b1);
    endtask

    task automatic test_size_limits();
        configure(12'd3, 12'd1, 12'd0);
        send_frame(3, 1'b1);
        configure(12'd5, 12'd5, 12'd2);
        send_frame(25, 1'b1);
        configure(12'd3, 12'd3, 12'd4);
        send_frame(9, 1'b1);
        configure(12'd16, 12'd16, 12'hFFF);
        for (int unsigned i = 0; i < 256; i++) send_pixel(8'hFF, 8'hFF, 8'hFF, i == 0);
        configure(12'd0, 12'd0, 12'd1);
        send_frame(1, 1'b1);
        send_frame(2, 1'b0);
        wait_idle();
        write_reg(CFG_UNUSED, 12'hFFF);
        send_frame(1, 1'b0);
    endtask

    task automatic test_height_change_mid_frame();
        configure(12'd4, 12'd8, 12'd2);
        send_frame(12, 1'b1);
        wait_idle();
        write_reg(CFG_SOURCE_HEIGHT, 12'd4);
        send_frame(4, 1'b0);
        send_frame(4, 1'b0);
        wait_idle();
        write_reg(CFG_SOURCE_HEIGHT, 12'd6);
        send_frame(20, 1'b0);
    endtask

    task automatic test_output_back_pressure();
        configure(12'd8, 12'd4, 12'd1);
        long_hold_req = LONG_HOLD;
        repeat (2) send_frame(32, 1'b1);
        wait_idle();
        send_frame(32, 1'b0);
    endtask

    task automatic test_random_frames();
        int unsigned start;
        int unsigned r;
        int unsigned fac;
        int unsigned eff;
        int unsigned w;
        int unsigned h;
        int unsigned n;
        bit          fs;
        bit          reconfig;
        start    = sent_items;
        reconfig = 1'b1;
        while (sent_items - start < RANDOM_ITEMS) begin
            if (reconfig || $urandom_range(0, 1) == 0) begin
                r = $urandom_range(0, 15);
                if (r == 0) fac = $urandom_range(16, 31);
                else if (r == 1) fac = 0;
                else if (r <= 3) fac = $urandom_range(5, 8);
                else fac = $urandom_range(1, 4);
                eff = clamp_size(fac, DEF_MAX_FACTOR);
                w = eff * $urandom_range(1, (eff > 4) ? 2 : 6);
                h = eff * $urandom_range(1, (eff > 4) ? 1 : 4);
                if ($urandom_range(0, 3) == 0) w += $urandom_range(0, eff - 1);
                if ($urandom_range(0, 3) == 0) h += $urandom_range(0, eff - 1);
                configure(CFG_W'(w), CFG_W'(h), CFG_W'(fac));
                fs = 1'b1;
            end else begin
                fs = ($urandom_range(0, 2) == 0);
            end
            reconfig = 1'b0;
            n = frame_pixels();
            // Now and then a frame is cut short or restarted part way through.
            if ($urandom_range(0, 7) == 0) n = $urandom_range(1, n);
            if (n > RANDOM_ITEMS - (sent_items - start)) begin
                n = RANDOM_ITEMS - (sent_items - start);
            end
            for (int unsigned i = 0; i < n; i++) begin
                send_pixel(PIX_W'($urandom_range(0, 255)), PIX_W'($urandom_range(0, 255)),
                           PIX_W'($urandom_range(0, 255)),
                           (i == 0) ? fs : ($urandom_range(0, 63) == 0));
            end
            if ($urandom_range(0, 3) == 0) wait_idle();
        end
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        configure(12'd6, 12'd4, 12'd2);
        repeat (2) send_frame(24, 1'b1);
        configure(12'd9, 12'd3, 12'd3);
        send_frame(27, 1'b1);
    endtask

    always @(posedge i_clk) begin
        if (long_hold_req > 0) begin
            stall_left    = long_hold_req;
            long_hold_req = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_avgs
        t_avg_pix got;
        t_avg_pix want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_avg_a, o_avg_b, o_avg_c, o_line_end, o_frame_end};
            if (pending_avgs.size() == 0) begin
                if (mismatches < MAX_SHOWN) begin
                    $display("unexpected transaction: a=%0d b=%0d c=%0d le=%0b fe=%0b",
                             got.a, got.b, got.c, got.line_end, got.frame_end);
                end
                mismatches++;
            end else begin
                want = pending_avgs.pop_front();
                if (got !== want) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("mismatch: expected a=%0d b=%0d c=%0d le=%0b fe=%0b",
                                 want.a, want.b, want.c, want.line_end, want.frame_end);
                        $display("          got      a=%0d b=%0d c=%0d le=%0b fe=%0b",
                                 got.a, got.b, got.c, got.line_end, got.frame_end);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall)
                || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_directed_blocks();
        test_size_limits();
        test_height_change_mid_frame();
        test_output_back_pressure();
        test_random_frames();
        test_steady_stream();
        wait_idle();
        if (mismatches == 0 && pending_avgs.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
